// ===== design/rcts_pkg.sv =====
// shared types and constants for the roi cell temporal smoother
`timescale 1ns / 1ps

package rcts_pkg;

    localparam int LevelW = 2;
    localparam int LevelCount = 4;
    localparam logic [LevelW-1:0] LevelMax = LevelW'(LevelCount - 1);

    localparam int HoldW = 8;
    localparam int GridW = 13;
    localparam int CfgDataW = 13;
    localparam int CfgIndexW = 1;

    localparam logic [CfgIndexW-1:0] RegHoldFrames = 1'b0;
    localparam logic [CfgIndexW-1:0] RegGridCells = 1'b1;

    localparam logic [HoldW-1:0] HoldFramesReset = 8'd3;
    localparam logic [GridW-1:0] GridCellsReset = 13'd4096;

    typedef struct packed {
        logic [LevelW-1:0] cell_level;
        logic              last_cell;
    } in_item_t;

    typedef struct packed {
        logic [LevelW-1:0] smoothed_level;
        logic              frame_end;
    } out_item_t;

    typedef struct packed {
        logic [LevelW-1:0] level;
        logic [HoldW-1:0]  count;
    } cell_entry_t;

endpackage

// ===== design/rcts_stream_if.sv =====
// valid/ready stream channel carrying one payload item per transfer
`timescale 1ns / 1ps

interface rcts_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/rcts_cell_mem.sv =====
// per-cell state memory with registered read and write-to-read bypass
`timescale 1ns / 1ps

module rcts_cell_mem
    import rcts_pkg::*;
#(
    parameter int Depth = 4096,
    parameter int AddrW = 12
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  cell_entry_t      wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output cell_entry_t      rd_data
);

    cell_entry_t mem [Depth];
    cell_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // same-edge write to the address being read wins
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/rcts_out_stage.sv =====
// result register with skid entry so input keeps flowing while one result waits under output stall
`timescale 1ns / 1ps

module rcts_out_stage
    import rcts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_data,
    output logic      can_push,
    rcts_stream_if.source result
);

    logic      main_valid_reg;
    logic      main_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_item_t main_reg;
    out_item_t main_next;
    out_item_t skid_reg;
    out_item_t skid_next;
    logic      pop;

    assign can_push = !skid_valid_reg;
    assign pop = main_valid_reg && result.ready;
    assign result.valid = main_valid_reg;
    assign result.payload = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next = main_reg;
        skid_next = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== design/roi_cell_temporal_smoother.sv =====
// top level of the roi cell temporal smoother
`timescale 1ns / 1ps

// Smooths a region-of-interest priority map over time, one cell per transfer in raster
// order. Each accepted cell's result lands in the output stage on the same edge, so one
// cell per cycle is sustained while the skid entry is free; a two-entry stage keeps the
// input open while one result waits downstream. The next cell's state is prefetched from
// the per-cell memory (one write and one registered read per cycle, with bypass), so the
// memory port sets the rate of one cell per cycle. The first frame after reset or after a
// grid_cells write passes through and initialises the map; no clearing pass is needed.

module roi_cell_temporal_smoother
    import rcts_pkg::*;
#(
    parameter int MAX_CELLS = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_wdata,
    rcts_stream_if.sink          cell_in,
    rcts_stream_if.source        cell_out
);

    localparam int PosW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CntW = $clog2(MAX_CELLS + 1);
    localparam int CmpW = (CntW > GridW) ? CntW : GridW;
    localparam logic [CmpW-1:0] MaxCellsW = CmpW'(MAX_CELLS);

    logic [HoldW-1:0] hold_frames_reg;
    logic [GridW-1:0] grid_cells_reg;
    logic             has_history_reg;
    logic             has_history_next;
    logic [PosW-1:0]  pos_reg;
    logic [PosW-1:0]  pos_next;

    logic [CmpW-1:0]  grid_w;
    logic [CmpW-1:0]  cells_w;
    logic [PosW-1:0]  last_pos;
    logic             at_last;

    logic             accept;
    logic             can_push;
    logic [LevelW-1:0] level;
    cell_entry_t      prev_entry;
    cell_entry_t      new_entry;
    logic [HoldW:0]   count_inc;
    out_item_t        result_item;

    assign accept = cell_in.valid && cell_in.ready;
    assign cell_in.ready = can_push;

    // effective grid size, clamped to one and to the memory depth
    assign grid_w = CmpW'(grid_cells_reg);
    always_comb
    begin
        if (grid_w == '0)
        begin
            cells_w = CmpW'(1);
        end
        else if (grid_w > MaxCellsW)
        begin
            cells_w = MaxCellsW;
        end
        else
        begin
            cells_w = grid_w;
        end
    end
    assign last_pos = PosW'(cells_w - CmpW'(1));
    assign at_last = (pos_reg == last_pos);

    always_comb
    begin
        if (cell_in.payload.cell_level > LevelMax)
        begin
            level = LevelMax;
        end
        else
        begin
            level = cell_in.payload.cell_level;
        end
    end

    assign count_inc = {1'b0, prev_entry.count} + (HoldW+1)'(1);

    always_comb
    begin
        new_entry.level = level;
        new_entry.count = '0;
        if (has_history_reg && (level < prev_entry.level))
        begin
            if (count_inc < {1'b0, hold_frames_reg})
            begin
                new_entry.level = prev_entry.level;
                new_entry.count = count_inc[HoldW-1:0];
            end
            else
            begin
                new_entry.level = prev_entry.level - LevelW'(1);
            end
        end
    end

    assign result_item.smoothed_level = new_entry.level;
    assign result_item.frame_end = cell_in.payload.last_cell;

    always_comb
    begin
        pos_next = pos_reg;
        has_history_next = has_history_reg;
        if (cfg_wen && (cfg_index == RegGridCells))
        begin
            pos_next = '0;
            has_history_next = 1'b0;
        end
        else if (accept)
        begin
            if (cell_in.payload.last_cell)
            begin
                pos_next = '0;
                has_history_next = at_last;
            end
            else if (at_last)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + PosW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_frames_reg <= HoldFramesReset;
            grid_cells_reg <= GridCellsReset;
            has_history_reg <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            if (cfg_wen && (cfg_index == RegHoldFrames))
            begin
                hold_frames_reg <= cfg_wdata[HoldW-1:0];
            end
            if (cfg_wen && (cfg_index == RegGridCells))
            begin
                grid_cells_reg <= cfg_wdata[GridW-1:0];
            end
            has_history_reg <= has_history_next;
            pos_reg <= pos_next;
        end
    end

    // read address runs one cell ahead so the entry is ready when the cell arrives
    rcts_cell_mem #(
        .Depth (MAX_CELLS),
        .AddrW (PosW)
    ) u_cell_mem (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (pos_reg),
        .wr_data (new_entry),
        .rd_addr (pos_next),
        .rd_data (prev_entry)
    );

    rcts_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result_item),
        .can_push  (can_push),
        .result    (cell_out)
    );

endmodule

// ===== bench/roi_cell_temporal_smoother_test.sv =====
// self-checking testbench for the roi cell temporal smoother
`timescale 1ns / 1ps

module roi_cell_temporal_smoother_test;
    import rcts_pkg::*;

    localparam int MaxCells = 4096;
    localparam int LongStall = 200;
    localparam int DrainCycles = 8;

    typedef struct packed {
        bit                   is_write;
        logic [CfgIndexW-1:0] reg_index;
        logic [CfgDataW-1:0]  reg_value;
        logic [LevelW-1:0]    level;
        bit                   last;
        bit                   typed;
        logic [LevelW-1:0]    want;
    } plan_row_t;

    localparam int PlanRows = 30;

    localparam plan_row_t DirectedPlan [PlanRows] = '{
        '{1'b0, RegHoldFrames, 13'd0, 2'd3, 1'b0, 1'b1, 2'd3},
        '{1'b0, RegHoldFrames, 13'd0, 2'd0, 1'b0, 1'b1, 2'd0},
        '{1'b0, RegHoldFrames, 13'd0, 2'd2, 1'b1, 1'b1, 2'd2},
        '{1'b1, RegHoldFrames, 13'd0, 2'd0, 1'b0, 1'b0, 2'd0},
        '{1'b1, RegGridCells, 13'd0, 2'd0, 1'b0, 1'b0, 2'd0},
        '{1'b0, RegHoldFrames, 13'd0, 2'd3, 1'b1, 1'b1, 2'd3},
        '{1'b0, RegHoldFrames, 13'd0, 2'd0, 1'b1, 1'b1, 2'd2},
        '{1'b0, RegHoldFrames, 13'd0, 2'd0, 1'b1, 1'b1, 2'd1},
        '{1'b0, RegHoldFrames, 13'd0, 2'd1, 1'b1, 1'b1, 2'd1},
        '{1'b0, RegHoldFrames, 13'd0, 2'd0, 1'b1, 1'b1, 2'd0},
        '{1'b0, RegHoldFrames, 13'd0, 2'd3, 1'b1, 1'b1, 2'd3},
        '{1'b1, RegHoldFrames, 13'd255, 2'd0, 1'b0, 1'b0, 2'd0},
        '{1'b0, RegHoldFrames, 13'd0, 2'd2, 1'b1, 1'b1, 2'd3},
        '{1'b0, RegHoldFrames, 13'd0, 2'd1, 1'b1, 1'b1, 2'd3},
        '{1'b1, RegHoldFrames, 13'd2, 2'd0, 1'b0, 1'b0, 2'd0},
        '{1'b0, RegHoldFrames, 13'd0, 2'd0, 1'b1, 1'b0, 2'd0},
        '{1'b1, RegGridCells, 13'd3, 2'd0, 1'b0, 1'b0, 2'd0},
        '{1'b0, RegHoldFrames, 13'd0, 2'd1, 1'b0, 1'b1, 2'd1},
        '{1'b0, RegHoldFrames, 13'd0, 2'd2, 1'b0, 1'b1, 2'd2},
        '{1'b0, RegHoldFrames, 13'd0, 2'd3, 1'b1, 1'b1, 2'd3},
        '{1'b0, RegHoldFrames, 13'd0, 2'd0, 1'b0, 1'b0, 2'd0},
        '{1'b0, RegHoldFrames, 13'd0, 2'd0, 1'b0, 1'b0, 2'd0},
        '{1'b0, RegHoldFrames, 13'd0, 2'd0, 1'b1, 1'b0, 2'd0},
        '{1'b0, RegHoldFrames, 13'd0, 2'd0, 1'b0, 1'b0, 2'd0},
        '{1'b0, RegHoldFrames, 13'd0, 2'd2, 1'b1, 1'b0, 2'd0},
        '{1'b0, RegHoldFrames, 13'd0, 2'd0, 1'b0, 1'b1, 2'd0},
        '{1'b0, RegHoldFrames, 13'd0, 2'd1, 1'b0, 1'b1, 2'd1},
        '{1'b0, RegHoldFrames, 13'd0, 2'd2, 1'b0, 1'b1, 2'd2},
        '{1'b0, RegHoldFrames, 13'd0, 2'd3, 1'b0, 1'b1, 2'd3},
        '{1'b0, RegHoldFrames, 13'd0, 2'd0, 1'b1, 1'b1, 2'd0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_wdata;

    rcts_stream_if #(.payload_t(in_item_t))  cell_in_ch ();
    rcts_stream_if #(.payload_t(out_item_t)) cell_out_ch ();

    roi_cell_temporal_smoother #(
        .MAX_CELLS(MaxCells)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cell_in  (cell_in_ch),
        .cell_out (cell_out_ch)
    );

    // smoothing state mirrored from the block
    logic [LevelW-1:0] held_level [MaxCells];
    logic [HoldW-1:0]  weak_frames [MaxCells];
    bit                map_primed;
    int                next_cell;
    logic [HoldW-1:0]  hold_setting;
    logic [GridW-1:0]  grid_setting;

    out_item_t smoothed_queue [$];

    int fail_count;
    int cells_sent;
    int frames_sent;
    int results_seen;
    int reg_writes;
    int burst_left;
    int stall_requests;
    int stall_served;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int grid_in_use();
        if (grid_setting == '0)
            return 1;
        if (int'(grid_setting) > MaxCells)
            return MaxCells;
        return int'(grid_setting);
    endfunction

    function automatic out_item_t smooth_cell(in_item_t c);
        logic [LevelW-1:0] lvl;
        logic [LevelW-1:0] res;
        logic [HoldW:0]    cnt;
        int                cells;
        int                p;
        out_item_t         r;
        lvl = c.cell_level;
        if (lvl > LevelMax)
            lvl = LevelMax;
        cells = grid_in_use();
        p = next_cell;
        if (p >= cells)
            p = 0;
        if (!map_primed || lvl >= held_level[p]) begin
            res = lvl;
            weak_frames[p] = '0;
        end else begin
            cnt = {1'b0, weak_frames[p]} + 1'b1;
            if (cnt < {1'b0, hold_setting}) begin
                res = held_level[p];
                weak_frames[p] = cnt[HoldW-1:0];
            end else begin
                res = held_level[p] - 1'b1;
                weak_frames[p] = '0;
            end
        end
        held_level[p] = res;
        if (c.last_cell) begin
            map_primed = (p == cells - 1);
            next_cell = 0;
        end else begin
            next_cell = (p + 1 >= cells) ? 0 : p + 1;
        end
        r.smoothed_level = res;
        r.frame_end = c.last_cell;
        return r;
    endfunction

    task automatic note_failure(string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    // sender bursts with random gaps, sometimes long stretches with no gap
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = 64;
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(1, 6);
            end
            repeat (gap) begin
                @(negedge clk);
                cell_in_ch.valid <= 1'b0;
                cell_in_ch.payload <= in_item_t'($urandom);
            end
        end
        burst_left--;
    endtask

    task automatic send_cell(logic [LevelW-1:0] lvl, bit last, bit typed,
                             logic [LevelW-1:0] want);
        in_item_t  c;
        out_item_t r;
        pace();
        c.cell_level = lvl;
        c.last_cell = last;
        @(negedge clk);
        cell_in_ch.valid <= 1'b1;
        cell_in_ch.payload <= c;
        @(posedge clk);
        while (!cell_in_ch.ready)
            @(posedge clk);
        r = smooth_cell(c);
        if (typed)
            r.smoothed_level = want;
        smoothed_queue.push_back(r);
        cells_sent++;
        if (last)
            frames_sent++;
    endtask

    task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
        @(negedge clk);
        cell_in_ch.valid <= 1'b0;
        while (smoothed_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen <= 1'b0;
        if (idx == RegHoldFrames) begin
            hold_setting = value[HoldW-1:0];
        end else begin
            grid_setting = value[GridW-1:0];
            map_primed = 1'b0;
            next_cell = 0;
        end
        reg_writes++;
    endtask

    task automatic run_random_phase(bit first);
        logic [HoldW-1:0] h;
        logic [GridW-1:0] g;
        int               cells;
        int               frames;
        int               n;
        int               kind;
        bit               falling;
        case ($urandom_range(0, 5))
            0: h = 8'd0;
            1: h = 8'd1;
            2: h = 8'd2;
            3: h = 8'd3;
            4: h = HoldW'($urandom_range(4, 10));
            default: h = HoldW'($urandom_range(0, 255));
        endcase
        if (first || $urandom_range(0, 3) != 0)
            write_reg(RegHoldFrames, CfgDataW'(h));
        if (first || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
                0: g = '0;
                1: g = GridW'($urandom_range(9, 48));
                default: g = GridW'($urandom_range(1, 8));
            endcase
            write_reg(RegGridCells, CfgDataW'(g));
        end
        if (first)
            stall_requests++;
        cells = grid_in_use();
        frames = $urandom_range(4, 14);
        for (int f = 0; f < frames; f++) begin
            kind = $urandom_range(0, 9);
            n = cells;
            if (kind == 0 && cells > 1)
                n = $urandom_range(1, cells - 1);
            else if (kind == 1)
                n = cells + $urandom_range(1, cells + 2);
            falling = $urandom_range(0, 1);
            for (int k = 0; k < n; k++)
                send_cell(falling ? LevelW'($urandom_range(0, 1)) : LevelW'($urandom_range(0, 3)),
                          k == n - 1, 1'b0, '0);
        end
    endtask

    // receiver stall pattern, plus one long hold-off on request
    initial begin : receiver
        int mode;
        int mode_left;
        int stall_left;
        mode = 0;
        mode_left = 0;
        stall_left = 0;
        cell_out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_served != stall_requests) begin
                stall_served++;
                stall_left = LongStall;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                cell_out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: cell_out_ch.ready <= 1'b1;
                    1: cell_out_ch.ready <= 1'($urandom_range(0, 1));
                    2: cell_out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: cell_out_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && cell_out_ch.valid && cell_out_ch.ready) begin
            results_seen++;
            if (smoothed_queue.size() == 0) begin
                note_failure($sformatf("unexpected transfer: level %0d end %0b",
                                       cell_out_ch.payload.smoothed_level,
                                       cell_out_ch.payload.frame_end));
            end else begin
                want = smoothed_queue.pop_front();
                if (cell_out_ch.payload.smoothed_level !== want.smoothed_level)
                    note_failure($sformatf("smoothed_level: expected %0d, got %0d",
                                           want.smoothed_level,
                                           cell_out_ch.payload.smoothed_level));
                if (cell_out_ch.payload.frame_end !== want.frame_end)
                    note_failure($sformatf("frame_end: expected %0b, got %0b",
                                           want.frame_end, cell_out_ch.payload.frame_end));
            end
        end
    end

    initial begin
        int random_cells;
        fail_count = 0;
        cells_sent = 0;
        frames_sent = 0;
        results_seen = 0;
        reg_writes = 0;
        burst_left = 0;
        stall_requests = 0;
        stall_served = 0;
        map_primed = 1'b0;
        next_cell = 0;
        hold_setting = HoldFramesReset;
        grid_setting = GridCellsReset;
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cell_in_ch.valid = 1'b0;
        cell_in_ch.payload = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DirectedPlan[i]) begin
            if (DirectedPlan[i].is_write)
                write_reg(DirectedPlan[i].reg_index, DirectedPlan[i].reg_value);
            else
                send_cell(DirectedPlan[i].level, DirectedPlan[i].last,
                          DirectedPlan[i].typed, DirectedPlan[i].want);
        end

        // repeated weaker frames on a single cell
        write_reg(RegGridCells, 13'd1);
        write_reg(RegHoldFrames, 13'd5);
        send_cell(2'd3, 1'b1, 1'b0, '0);
        repeat (30)
            send_cell(LevelW'($urandom_range(0, 1)), 1'b1, 1'b0, '0);

        random_cells = cells_sent;
        run_random_phase(1'b1);
        while (cells_sent - random_cells < 300)
            run_random_phase(1'b0);

        // grid above the memory depth over a partial frame
        write_reg(RegHoldFrames, CfgDataW'($urandom_range(0, 3)));
        write_reg(RegGridCells, 13'd8191);
        for (int k = 0; k < 40; k++)
            send_cell(LevelW'($urandom_range(0, 3)), k == 39, 1'b0, '0);

        @(negedge clk);
        cell_in_ch.valid <= 1'b0;
        while (smoothed_queue.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("sent %0d cells in %0d frames with %0d register writes, %0d results checked",
                 cells_sent, frames_sent, reg_writes, results_seen);
        $display("grid sizes 0 to 48 and one above the %0d-cell memory, hold counts 0 to 255",
                 MaxCells);
        $display("%0d mismatches", fail_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rcts_pkg.sv
design/rcts_stream_if.sv
design/rcts_cell_mem.sv
design/rcts_out_stage.sv
design/roi_cell_temporal_smoother.sv
bench/roi_cell_temporal_smoother_test.sv
